// ===== design/link_cell_deframer_defines.svh =====
// assertion macros used by the deframer checker
`ifndef LINK_CELL_DEFRAMER_DEFINES_SVH
`define LINK_CELL_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lcd_pkg.sv =====
`default_nettype none

package lcd_pkg;

  // fixed cell payload size
  localparam logic [15:0] FIXED_PAYLOAD_BYTES = 16'd509;

  // header and buffer limits
  localparam logic [16:0] MIN_BUFFER      = 17'd5;
  localparam logic [16:0] COUNT_MAX       = 17'h1FFFF;
  localparam logic [7:0]  VAR_CMD_LOW     = 8'd128;
  localparam logic [7:0]  VERSIONS_CMD    = 8'd7;
  localparam logic [7:0]  WIDE_ID_VERSION = 8'd4;
  localparam logic [2:0]  NARROW_ID_LEN   = 3'd2;
  localparam logic [2:0]  WIDE_ID_LEN     = 3'd4;

  // parse phase
  typedef enum logic [2:0] {
    PH_CIRC,
    PH_CMD,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD
  } phase_t;

  // summary status codes
  typedef enum logic [1:0] {
    ST_OK,
    ST_SHORT_BUFFER,
    ST_NO_LENGTH,
    ST_SHORT_PAYLOAD
  } status_t;

  // one result transaction
  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        cell_done;
    status_t     status;
    logic [31:0] circuit_id;
    logic [7:0]  command_code;
    logic        variable_cell;
    logic [15:0] payload_length;
    logic [16:0] total_bytes;
  } result_t;

  // versions cell or any command from 128 up
  function automatic logic is_variable(input logic [7:0] cmd);
    return (cmd == VERSIONS_CMD) || (cmd >= VAR_CMD_LOW);
  endfunction

endpackage

`default_nettype wire

// ===== design/lcd_parser.sv =====
`default_nettype none

module lcd_parser #(
  parameter logic [15:0] FIXED_PAYLOAD_BYTES = lcd_pkg::FIXED_PAYLOAD_BYTES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_write,
  input  wire logic [7:0]      cfg_data,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            last_byte,
  output lcd_pkg::result_t     result
);

  logic [7:0]       link_version;
  lcd_pkg::phase_t  phase, phase_next;
  logic [2:0]       header_count, header_count_next;
  logic [31:0]      circuit_acc, circuit_acc_next;
  logic [7:0]       command_reg, command_reg_next;
  logic [15:0]      length_acc, length_acc_next;
  logic [16:0]      buffer_count, buffer_count_next;
  logic [15:0]      payload_count, payload_count_next;
  logic [2:0]       id_len;
  logic [15:0]      limit;
  logic             var_cell;

  // link version register
  always_ff @(posedge clk) begin
    if (rst) begin
      link_version <= '0;
    end else if (cfg_write) begin
      link_version <= cfg_data;
    end
  end

  // next parse state and result for the incoming byte
  always_comb begin
    phase_next         = phase;
    header_count_next  = header_count;
    circuit_acc_next   = circuit_acc;
    command_reg_next   = command_reg;
    length_acc_next    = length_acc;
    payload_count_next = payload_count;
    result             = '0;

    buffer_count_next = (buffer_count != lcd_pkg::COUNT_MAX) ?
                        buffer_count + 17'd1 : buffer_count;
    id_len = (link_version < lcd_pkg::WIDE_ID_VERSION) ?
             lcd_pkg::NARROW_ID_LEN : lcd_pkg::WIDE_ID_LEN;
    limit  = lcd_pkg::is_variable(command_reg) ?
             length_acc : FIXED_PAYLOAD_BYTES;

    case (phase)
      lcd_pkg::PH_CIRC: begin
        circuit_acc_next  = {circuit_acc[23:0], data_byte};
        header_count_next = header_count + 3'd1;
        if (header_count_next >= id_len) begin
          phase_next = lcd_pkg::PH_CMD;
        end
      end
      lcd_pkg::PH_CMD: begin
        command_reg_next = data_byte;
        phase_next = lcd_pkg::is_variable(data_byte) ?
                     lcd_pkg::PH_LEN_HI : lcd_pkg::PH_PAYLOAD;
      end
      lcd_pkg::PH_LEN_HI: begin
        length_acc_next = {data_byte, 8'd0};
        phase_next      = lcd_pkg::PH_LEN_LO;
      end
      lcd_pkg::PH_LEN_LO: begin
        length_acc_next = {length_acc[15:8], data_byte};
        phase_next      = lcd_pkg::PH_PAYLOAD;
      end
      default: begin
        // payload byte, dropped past the limit
        if (payload_count < limit) begin
          result.byte_valid    = 1'b1;
          result.payload_byte  = data_byte;
          result.payload_index = payload_count;
          payload_count_next   = payload_count + 16'd1;
        end
      end
    endcase

    var_cell = lcd_pkg::is_variable(command_reg_next);

    // summary on the final byte
    if (last_byte) begin
      result.cell_done = 1'b1;
      if (buffer_count_next < lcd_pkg::MIN_BUFFER ||
          phase_next == lcd_pkg::PH_CIRC || phase_next == lcd_pkg::PH_CMD) begin
        result.status = lcd_pkg::ST_SHORT_BUFFER;
      end else begin
        result.circuit_id    = circuit_acc_next;
        result.command_code  = command_reg_next;
        result.variable_cell = var_cell;
        if (var_cell && (phase_next == lcd_pkg::PH_LEN_HI ||
                         phase_next == lcd_pkg::PH_LEN_LO)) begin
          result.status = lcd_pkg::ST_NO_LENGTH;
        end else if (var_cell && payload_count_next < length_acc_next) begin
          result.status = lcd_pkg::ST_SHORT_PAYLOAD;
        end else begin
          result.payload_length = payload_count_next;
          result.total_bytes    = {14'd0, header_count_next} + 17'd1 +
                                  {15'd0, var_cell, 1'b0} + {1'b0, payload_count_next};
        end
      end
    end
  end

  // parse state, cleared after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lcd_pkg::PH_CIRC;
      header_count  <= '0;
      circuit_acc   <= '0;
      command_reg   <= '0;
      length_acc    <= '0;
      buffer_count  <= '0;
      payload_count <= '0;
    end else if (accept) begin
      if (last_byte) begin
        phase         <= lcd_pkg::PH_CIRC;
        header_count  <= '0;
        circuit_acc   <= '0;
        command_reg   <= '0;
        length_acc    <= '0;
        buffer_count  <= '0;
        payload_count <= '0;
      end else begin
        phase         <= phase_next;
        header_count  <= header_count_next;
        circuit_acc   <= circuit_acc_next;
        command_reg   <= command_reg_next;
        length_acc    <= length_acc_next;
        buffer_count  <= buffer_count_next;
        payload_count <= payload_count_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/lcd_out_buf.sv =====
`default_nettype none

module lcd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lcd_pkg::result_t  push_result,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output lcd_pkg::result_t       out_result,
  output logic                   full
);

  lcd_pkg::result_t skid_result;
  logic             skid_valid;
  logic             take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // payload moves with the control above
  always_ff @(posedge clk) begin
    if (push) begin
      if (!out_valid || take) begin
        out_result <= push_result;
      end else begin
        skid_result <= push_result;
      end
    end else if (take && skid_valid) begin
      out_result <= skid_result;
    end
  end

endmodule

`default_nettype wire

// ===== design/link_cell_deframer.sv =====
`default_nettype none

// Link cell deframer: takes a received buffer one byte per transaction and
// returns exactly one result transaction per byte; a new byte is taken every
// cycle while in_stall is low, so the sustained rate is one byte per clock,
// set by the combinational parse step between the parse state registers and
// the output register. Payload bytes come out as they arrive, before the cell
// is known to be valid, so discard them when the summary on the final byte
// reports a nonzero status. link_version must be written with cfg_write/
// cfg_data only while the block is idle, a rule for the user that the block
// does not enforce. It decides the circuit id width (two bytes below version 4,
// four bytes otherwise). A two-entry output buffer lets one more byte in
// while a result waits; in_stall rises only when both entries are held.
module link_cell_deframer #(
  parameter logic [15:0] FIXED_PAYLOAD_BYTES = lcd_pkg::FIXED_PAYLOAD_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             byte_valid,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_index,
  output logic             cell_done,
  output logic [1:0]       status,
  output logic [31:0]      circuit_id,
  output logic [7:0]       command_code,
  output logic             variable_cell,
  output logic [15:0]      payload_length,
  output logic [16:0]      total_bytes
);

  lcd_pkg::result_t parse_result;
  lcd_pkg::result_t held_result;
  logic             accept;

  assign accept = in_valid && !in_stall;

  // header parse and payload pass-through
  lcd_parser #(
    .FIXED_PAYLOAD_BYTES (FIXED_PAYLOAD_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .result    (parse_result)
  );

  // result register and skid entry
  lcd_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .push        (accept),
    .push_result (parse_result),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_result  (held_result),
    .full        (in_stall)
  );

  // result fields
  assign byte_valid     = held_result.byte_valid;
  assign payload_byte   = held_result.payload_byte;
  assign payload_index  = held_result.payload_index;
  assign cell_done      = held_result.cell_done;
  assign status         = held_result.status;
  assign circuit_id     = held_result.circuit_id;
  assign command_code   = held_result.command_code;
  assign variable_cell  = held_result.variable_cell;
  assign payload_length = held_result.payload_length;
  assign total_bytes    = held_result.total_bytes;

endmodule

`default_nettype wire

// ===== design/lcd_checker.sv =====
`default_nettype none

`include "link_cell_deframer_defines.svh"

module lcd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        byte_valid,
  input wire logic [7:0]  payload_byte,
  input wire logic [15:0] payload_index,
  input wire logic        cell_done,
  input wire logic [1:0]  status,
  input wire logic [31:0] circuit_id,
  input wire logic [7:0]  command_code,
  input wire logic        variable_cell,
  input wire logic [15:0] payload_length,
  input wire logic [16:0] total_bytes
);

  logic         header_clear;
  logic         sizes_clear;
  logic         summary_clear;
  logic         short_buffer;
  logic         error_status;
  logic         held;
  logic [101:0] result_bits;

  // field groups used by the checks below
  assign header_clear  = circuit_id == 32'd0 && command_code == 8'd0 && !variable_cell;
  assign sizes_clear   = payload_length == 16'd0 && total_bytes == 17'd0;
  assign summary_clear = status == lcd_pkg::ST_OK && header_clear && sizes_clear;
  assign short_buffer  = status == lcd_pkg::ST_SHORT_BUFFER;
  assign error_status  = status != lcd_pkg::ST_OK;
  assign held          = out_valid && out_stall;
  assign result_bits   = {byte_valid, payload_byte, payload_index, cell_done, status,
                          circuit_id, command_code, variable_cell, payload_length,
                          total_bytes};

  // summary fields stay clear on a transaction that ends no cell
  `LCD_ASSERT_NOW(a_no_summary, out_valid && !cell_done, summary_clear, "summary without cell_done")

  // a short buffer reports no header
  `LCD_ASSERT_NOW(a_short_header, out_valid && short_buffer, header_clear, "header on short buffer")

  // any error zeroes the sizes
  `LCD_ASSERT_NOW(a_error_sizes, out_valid && error_status, sizes_clear, "sizes reported on error")

  // input stalls only behind a held result
  `LCD_ASSERT_NOW(a_stall_held, in_stall, out_valid, "input stalled with no result pending")

  // a stalled result holds
  `LCD_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(result_bits), "stalled result changed")

endmodule

bind link_cell_deframer lcd_checker u_lcd_checker (.*);

`default_nettype wire
